>>> hdl/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg: shared types for the multilevel priority FIFO
// Item layouts, status codes and the classified command passed from the
// front end to the execution back end.
// ----------------------------------------------------------------------------
package mpf_pkg;

	localparam int TAG_W   = 32;
	localparam int LEVEL_W = 3;
	localparam int COUNT_W = 7;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_BAD_LEVEL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_BAD_LEVEL
	} op_t;

	typedef struct packed {
		logic               command;
		logic [LEVEL_W-1:0] level;
		logic [TAG_W-1:0]   patient_tag;
	} req_item_t;

	typedef struct packed {
		status_t            status;
		logic               popped_valid;
		logic [TAG_W-1:0]   popped_tag;
		logic [LEVEL_W-1:0] popped_level;
		logic [COUNT_W-1:0] total_count;
	} rsp_item_t;

	// classified command: level already checked, queue index is level - 1
	typedef struct packed {
		op_t                op;
		logic [LEVEL_W-1:0] qidx;
		logic [TAG_W-1:0]   tag;
	} cmd_t;

endpackage

>>> hdl/mpf_stream_if.sv
// ----------------------------------------------------------------------------
// mpf_stream_if: valid/ready channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface mpf_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/mpf_ram.sv
// ----------------------------------------------------------------------------
// mpf_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module mpf_ram #(
	parameter int  WIDTH  = 32,
	parameter int  DEPTH  = 80,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> hdl/mpf_front.sv
// ----------------------------------------------------------------------------
// mpf_front: request intake
// Accept request transactions, classify them and hold them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mpf_front import mpf_pkg::*; #(
	parameter int LEVELS = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	mpf_stream_if.sink   req,
	output logic         cmd_valid,
	output cmd_t         cmd,
	input  logic         cmd_take
);

	cmd_t       cmd_mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;

	// classify: a push with level zero or above the top level is rejected
	always_comb begin
		cls.tag  = req.data.patient_tag;
		cls.qidx = req.data.level - LEVEL_W'(1);
		if (req.data.command == CMD_POP) begin
			cls.op = OP_POP;
		end else if (req.data.level == '0 || int'(req.data.level) > LEVELS) begin
			cls.op = OP_BAD_LEVEL;
		end else begin
			cls.op = OP_PUSH;
		end
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = cmd_mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_take) begin
				rd_q <= ~rd_q;
			end
			case ({push, cmd_take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem_q[wr_q] <= cls;
		end
	end

endmodule

>>> hdl/mpf_back.sv
// ----------------------------------------------------------------------------
// mpf_back: command execution
// Update per-level pointers and counts, drive the tag memory and build the
// response in an output register.
// ----------------------------------------------------------------------------
module mpf_back import mpf_pkg::*; #(
	parameter int  LEVELS          = 5,
	parameter int  PER_LEVEL_DEPTH = 16,
	localparam int ADDR_W          = $clog2(LEVELS * PER_LEVEL_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_take,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_addr,
	output logic [TAG_W-1:0]  ram_wdata,
	input  logic [TAG_W-1:0]  ram_rdata,
	mpf_stream_if.source      rsp
);

	localparam int LIDX_W = $clog2(LEVELS);
	localparam int PTR_W  = $clog2(PER_LEVEL_DEPTH);
	localparam int OCC_W  = $clog2(PER_LEVEL_DEPTH + 1);
	localparam int TOT_W  = $clog2(LEVELS * PER_LEVEL_DEPTH + 1);

	typedef enum logic {S_IDLE, S_RESULT} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   rd_ptr_q [LEVELS];
	logic [PTR_W-1:0]   wr_ptr_q [LEVELS];
	logic [OCC_W-1:0]   occ_q    [LEVELS];
	logic [TOT_W-1:0]   total_q;
	status_t            pend_status_q;
	logic               pend_hit_q;
	logic [LEVEL_W-1:0] pend_level_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_data_q;

	logic               pop_found;
	logic [LIDX_W-1:0]  pop_q;
	logic [LIDX_W-1:0]  push_q;
	logic [LIDX_W-1:0]  sel_q;
	logic               push_full;
	logic [PTR_W-1:0]   ptr;
	logic [PTR_W-1:0]   ptr_next;

	// highest non-empty level wins
	always_comb begin
		pop_found = 1'b0;
		pop_q     = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (occ_q[l] != '0) begin
				pop_found = 1'b1;
				pop_q     = LIDX_W'(l);
			end
		end
	end

	assign push_q    = LIDX_W'(cmd.qidx);
	assign push_full = (occ_q[push_q] == OCC_W'(PER_LEVEL_DEPTH));
	assign sel_q     = (cmd.op == OP_POP) ? pop_q : push_q;
	assign ptr       = (cmd.op == OP_POP) ? rd_ptr_q[sel_q] : wr_ptr_q[sel_q];
	assign ptr_next  = (ptr == PTR_W'(PER_LEVEL_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);

	assign cmd_take  = (state_q == S_IDLE) && cmd_valid && (!rsp_valid_q || rsp.ready);
	assign ram_addr  = ADDR_W'(sel_q) * ADDR_W'(PER_LEVEL_DEPTH) + ADDR_W'(ptr);
	assign ram_we    = cmd_take && (cmd.op == OP_PUSH) && !push_full;
	assign ram_wdata = cmd.tag;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			total_q     <= '0;
			for (int l = 0; l < LEVELS; l++) begin
				rd_ptr_q[l] <= '0;
				wr_ptr_q[l] <= '0;
				occ_q[l]    <= '0;
			end
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						state_q    <= S_RESULT;
						pend_hit_q <= 1'b0;
						case (cmd.op)
							OP_PUSH: begin
								if (push_full) begin
									pend_status_q <= ST_FULL;
								end else begin
									pend_status_q    <= ST_OK;
									wr_ptr_q[push_q] <= ptr_next;
									occ_q[push_q]    <= occ_q[push_q] + OCC_W'(1);
									total_q          <= total_q + TOT_W'(1);
								end
							end
							OP_POP: begin
								if (pop_found) begin
									pend_status_q   <= ST_OK;
									pend_hit_q      <= 1'b1;
									pend_level_q    <= LEVEL_W'(pop_q) + LEVEL_W'(1);
									rd_ptr_q[pop_q] <= ptr_next;
									occ_q[pop_q]    <= occ_q[pop_q] - OCC_W'(1);
									total_q         <= total_q - TOT_W'(1);
								end else begin
									pend_status_q <= ST_EMPTY;
								end
							end
							default: begin
								pend_status_q <= ST_BAD_LEVEL;
							end
						endcase
					end
				end
				S_RESULT: begin
					state_q                 <= S_IDLE;
					rsp_valid_q             <= 1'b1;
					rsp_data_q.status       <= pend_status_q;
					rsp_data_q.popped_valid <= pend_hit_q;
					rsp_data_q.popped_tag   <= pend_hit_q ? ram_rdata : '0;
					rsp_data_q.popped_level <= pend_hit_q ? pend_level_q : '0;
					rsp_data_q.total_count  <= COUNT_W'(total_q);
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/multilevel_priority_fifo.sv
// ----------------------------------------------------------------------------
// multilevel_priority_fifo: priority queue with FIFO order per level
// Front end takes and classifies requests, back end keeps the level queues
// in one tag memory and answers every request with one response.
// ----------------------------------------------------------------------------
// A push appends its tag to the queue of levels 1..LEVELS; a pop returns the
// oldest tag of the highest non-empty level. Every request gets exactly one
// response with a status and the entry count held afterwards. For each
// request the back end first updates the level pointers and count and
// launches the tag memory access (S_IDLE), then takes the registered read
// data into the output register (S_RESULT). It takes no new request before
// the last one has reached the output register. A two-entry command queue
// lets requests arrive while the back end is busy or a response waits to be
// taken. The tag memory needs no clearing pass: an entry's data is only used
// after it was written.
module multilevel_priority_fifo import mpf_pkg::*; #(
	parameter int LEVELS          = 5,
	parameter int PER_LEVEL_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	mpf_stream_if.sink   req,
	mpf_stream_if.source rsp
);

	localparam int DEPTH  = LEVELS * PER_LEVEL_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);

	// front to back command handoff
	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_take;

	// tag memory port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [TAG_W-1:0]  ram_wdata;
	logic [TAG_W-1:0]  ram_rdata;

	// accept and classify requests, hold them until the back end is free
	mpf_front #(
		.LEVELS (LEVELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// execute commands and register responses
	mpf_back #(
		.LEVELS          (LEVELS),
		.PER_LEVEL_DEPTH (PER_LEVEL_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata),
		.rsp       (rsp)
	);

	// one region of PER_LEVEL_DEPTH slots per level
	mpf_ram #(
		.WIDTH (TAG_W),
		.DEPTH (DEPTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

>>> hdl/mpf_checker.sv
// ----------------------------------------------------------------------------
// mpf_checker: port-level assertions
// Watch the request and response channels of the priority FIFO.
// ----------------------------------------------------------------------------
module mpf_checker import mpf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_item_t rsp_data
);

	logic       req_fire;
	logic       rsp_fire;
	logic [2:0] open_q;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// requests accepted whose response has not been taken yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 3'd0;
		end else begin
			open_q <= open_q + 3'(req_fire) - 3'(rsp_fire);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> open_q != 3'd0)
		else $error("response without an open request");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 3'd4)
		else $error("more open requests than the block can hold");

	a_pop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.popped_valid |->
			rsp_data.status == ST_OK && rsp_data.popped_level != '0)
		else $error("popped entry with bad status or level");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_EMPTY |->
			rsp_data.total_count == '0 && !rsp_data.popped_valid)
		else $error("empty status with entries held");

endmodule

bind multilevel_priority_fifo mpf_checker u_mpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
